>>> rtl/core/ttl_expiry_queue_top_macros.svh
// Assertion macros shared by the TTL expiry queue modules.
// Self-contained; included by the controller and the datapath.
`ifndef TTL_EXPIRY_QUEUE_TOP_MACROS_SVH
`define TTL_EXPIRY_QUEUE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/teq_pkg.sv
// Shared types and constants for the TTL expiry queue.
// No dependencies; used by every module of the block.
package teq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int TAG_W   = 16;
   localparam int LEVEL_W = 2;
   localparam int TIME_W  = 32;
   localparam int LIFE_W  = 24;
   localparam int COUNT_W = 5;

   localparam logic [LIFE_W-1:0]  DEFAULT_LIFETIME = LIFE_W'(4000);
   localparam logic [COUNT_W-1:0] DEFAULT_VISIBLE  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] RESET_VISIBLE    = COUNT_W'(3);

   // Operation codes carried on req_kind.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  arrival;
      logic [LIFE_W-1:0]  lifetime;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_push;
      logic accept_tick;
      logic issue;
      logic eval;
      logic finish;
   } teq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rd_more;
   } teq_status_type;

endpackage

>>> rtl/core/teq_ctrl.sv
// Controller state machine of the TTL expiry queue.
// Depends on teq_pkg and the shared assertion macros.
`include "ttl_expiry_queue_top_macros.svh"

module teq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_kind,
   output logic                    busy,
   output logic                    rsp_strobe,
   output teq_pkg::teq_cmd_type    cmd,
   input  teq_pkg::teq_status_type st
);
   import teq_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      pend_ff;
   logic      strobe_ff;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   always_comb begin
      cmd.accept_push = accept && (req_kind == KIND_PUSH);
      cmd.accept_tick = accept && (req_kind == KIND_TICK);
      cmd.issue       = (state_ff == ST_WALK) && st.rd_more;
      cmd.eval        = (state_ff == ST_WALK) && pend_ff;
      cmd.finish      = (state_ff == ST_WALK) && !st.rd_more && !pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= cmd.issue;
         strobe_ff <= cmd.accept_push || cmd.finish;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept_tick) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (cmd.finish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `TEQ_ASSERT_SAME(a_strobe_when_idle, clock, reset, strobe_ff, !busy, "strobe while busy")
   `TEQ_ASSERT_NEXT(a_push_answers, clock, reset, cmd.accept_push, strobe_ff, "push gave no word")
   `TEQ_ASSERT_NEXT(a_tick_walks, clock, reset, cmd.accept_tick, busy && !strobe_ff, "tick not walked")

endmodule

>>> rtl/core/teq_datapath.sv
// Datapath of the TTL expiry queue: circular entry memory, walk counters, result words.
// Depends on teq_pkg and the shared assertion macros.
`include "ttl_expiry_queue_top_macros.svh"

module teq_datapath #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  teq_pkg::teq_cmd_type                cmd,
   output teq_pkg::teq_status_type             st,
   input  logic [teq_pkg::TIME_W-1:0]          req_now_time,
   input  logic [teq_pkg::LIFE_W-1:0]          req_lifetime,
   input  logic [teq_pkg::LEVEL_W-1:0]         req_severity,
   input  logic [teq_pkg::TAG_W-1:0]           req_payload_tag,
   input  logic                                csr_wr_en,
   input  logic [teq_pkg::COUNT_W-1:0]         csr_wr_data,
   output logic [teq_pkg::COUNT_W-1:0]         rsp_expired_count,
   output logic                                rsp_dropped_oldest,
   output logic [teq_pkg::COUNT_W-1:0]         rsp_occupancy,
   output logic [teq_pkg::COUNT_W-1:0]         rsp_visible_count
);
   import teq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   entry_type            entry_mem [DEPTH];
   entry_type            rd_ent_ff;
   logic [IDX_W-1:0]     head_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     rd_idx_ff;
   logic [CNT_W-1:0]     keep_ff;
   logic [CNT_W-1:0]     exp_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [COUNT_W-1:0]   vis_limit_ff;
   logic [COUNT_W-1:0]   rsp_expired_ff;
   logic                 rsp_dropped_ff;
   logic [COUNT_W-1:0]   rsp_occ_ff;
   logic [COUNT_W-1:0]   rsp_vis_ff;

   logic                 full;
   logic [CNT_W-1:0]     push_count;
   logic [CNT_W-1:0]     final_count;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   entry_type            wr_ent;
   entry_type            push_ent;
   logic [TIME_W-1:0]    age;
   logic                 expire;
   logic [COUNT_W-1:0]   cap;
   logic [WIDE_W-1:0]    occ_wide;
   logic [WIDE_W-1:0]    vis_wide;
   logic [WIDE_W-1:0]    exp_wide;

   // Slot of logical position pos counted from the oldest entry.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign push_count = full ? count_ff : count_ff + CNT_W'(1);
   assign st.rd_more = (rd_idx_ff != count_ff);
   assign rd_addr    = slot_of(head_ff, rd_idx_ff);

   assign age    = now_ff - rd_ent_ff.arrival;
   assign expire = (age >= TIME_W'(rd_ent_ff.lifetime));

   always_comb begin
      push_ent.tag      = req_payload_tag;
      push_ent.level    = req_severity;
      push_ent.arrival  = req_now_time;
      push_ent.lifetime = (req_lifetime == '0) ? DEFAULT_LIFETIME : req_lifetime;
      if (cmd.accept_push) begin
         wr_en   = 1'b1;
         wr_addr = slot_of(head_ff, count_ff);
         wr_ent  = push_ent;
      end else begin
         wr_en   = cmd.eval && !expire;
         wr_addr = slot_of(head_ff, keep_ff);
         wr_ent  = rd_ent_ff;
      end
   end

   // The result is built from the count that the finishing operation leaves.
   assign final_count = cmd.accept_push ? push_count : keep_ff;
   assign cap      = (vis_limit_ff == '0) ? DEFAULT_VISIBLE : vis_limit_ff;
   assign occ_wide = WIDE_W'(final_count);
   assign vis_wide = (occ_wide < WIDE_W'(cap)) ? occ_wide : WIDE_W'(cap);
   assign exp_wide = WIDE_W'(exp_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_ent;
      end
      if (cmd.issue) begin
         rd_ent_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         keep_ff      <= '0;
         exp_ff       <= '0;
         vis_limit_ff <= RESET_VISIBLE;
      end else begin
         if (csr_wr_en) begin
            vis_limit_ff <= csr_wr_data;
         end
         if (cmd.accept_push) begin
            count_ff <= push_count;
            if (full) begin
               head_ff <= slot_of(head_ff, CNT_W'(1));
            end
         end
         if (cmd.accept_tick) begin
            rd_idx_ff <= '0;
            keep_ff   <= '0;
            exp_ff    <= '0;
         end
         if (cmd.issue) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         if (cmd.eval) begin
            if (expire) begin
               exp_ff <= exp_ff + CNT_W'(1);
            end else begin
               keep_ff <= keep_ff + CNT_W'(1);
            end
         end
         if (cmd.finish) begin
            count_ff <= keep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_tick) begin
         now_ff <= req_now_time;
      end
      if (cmd.accept_push || cmd.finish) begin
         rsp_expired_ff <= cmd.accept_push ? '0 : exp_wide[COUNT_W-1:0];
         rsp_dropped_ff <= cmd.accept_push && full;
         rsp_occ_ff     <= occ_wide[COUNT_W-1:0];
         rsp_vis_ff     <= vis_wide[COUNT_W-1:0];
      end
   end

   assign rsp_expired_count  = rsp_expired_ff;
   assign rsp_dropped_oldest = rsp_dropped_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign rsp_visible_count  = rsp_vis_ff;

   `TEQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count overflow")
   `TEQ_ASSERT_SAME(a_keep_behind, clock, reset, cmd.eval, keep_ff < rd_idx_ff, "write passed read")
   `TEQ_ASSERT_SAME(a_walk_balance, clock, reset, cmd.finish,
      (CNT_W+1)'(exp_ff) + (CNT_W+1)'(keep_ff) == (CNT_W+1)'(count_ff), "entries lost in walk")
   `TEQ_ASSERT_NEXT(a_full_push_drops, clock, reset, cmd.accept_push && full,
      rsp_dropped_ff && (count_ff == CNT_W'(DEPTH)), "full push did not drop")

endmodule

>>> rtl/core/ttl_expiry_queue_top.sv
// Top level of the TTL expiry queue: an ordered, drop-oldest queue with timed expiry.
// Depends on teq_pkg, teq_ctrl and teq_datapath.
//
// An input word is taken at a rising edge where start is high and busy is low.
// req_kind selects a push (append one entry, dropping the oldest if the queue is
// full) or a tick (expire every entry whose age has reached its lifetime and
// compact the survivors in order).
// Every word taken yields exactly one result word on the rsp_ ports, valid for the
// single cycle in which rsp_strobe is high. The receiver cannot stall the block, so
// results must be captured in that cycle.
// A push answers in the cycle after it is taken and never raises busy, so pushes
// can be accepted on every cycle while no tick is walking.
// A tick walks the stored entries through the single read port of the entry
// memory, one entry per cycle; each read is registered before the entry is judged.
// Busy stays high until every stored entry has been read and judged, and
// rsp_strobe is high in the first cycle after busy falls.
// The csr_ port writes the visible limit; write it only while idle.
// Synchronous reset empties the queue and sets the visible limit to 3. The entry
// memory itself is not cleared, since only occupied slots are ever read.
module ttl_expiry_queue_top #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [teq_pkg::TIME_W-1:0]     req_now_time,
   input  logic [teq_pkg::LIFE_W-1:0]     req_lifetime,
   input  logic [teq_pkg::LEVEL_W-1:0]    req_severity,
   input  logic [teq_pkg::TAG_W-1:0]      req_payload_tag,
   input  logic                           csr_wr_en,
   input  logic [teq_pkg::COUNT_W-1:0]    csr_wr_data,
   output logic                           rsp_strobe,
   output logic [teq_pkg::COUNT_W-1:0]    rsp_expired_count,
   output logic                           rsp_dropped_oldest,
   output logic [teq_pkg::COUNT_W-1:0]    rsp_occupancy,
   output logic [teq_pkg::COUNT_W-1:0]    rsp_visible_count
);
   import teq_pkg::*;

   // Command and status links are the only connection between the two halves.
   teq_cmd_type    cmd;
   teq_status_type st;

   teq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .st         (st)
   );

   teq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_now_time       (req_now_time),
      .req_lifetime       (req_lifetime),
      .req_severity       (req_severity),
      .req_payload_tag    (req_payload_tag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_expired_count  (rsp_expired_count),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_visible_count  (rsp_visible_count)
   );

endmodule

>>> bench/ttl_expiry_queue_checker.sv
`timescale 1ns / 1ps
// Result checker for the TTL expiry queue: keeps its own copy of the queue,
// predicts the result word of every accepted request and compares it on rsp_.
// Depends on teq_pkg for widths, operation codes and default constants.
module ttl_expiry_queue_checker #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_kind,
   input  logic [teq_pkg::TIME_W-1:0]  req_now_time,
   input  logic [teq_pkg::LIFE_W-1:0]  req_lifetime,
   input  logic [teq_pkg::LEVEL_W-1:0] req_severity,
   input  logic [teq_pkg::TAG_W-1:0]   req_payload_tag,
   input  logic                        csr_wr_en,
   input  logic [teq_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                        rsp_strobe,
   input  logic [teq_pkg::COUNT_W-1:0] rsp_expired_count,
   input  logic                        rsp_dropped_oldest,
   input  logic [teq_pkg::COUNT_W-1:0] rsp_occupancy,
   input  logic [teq_pkg::COUNT_W-1:0] rsp_visible_count,
   output int                          fail_count,
   output int                          pending
);
   import teq_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] expired;
      logic               dropped;
      logic [COUNT_W-1:0] occupancy;
      logic [COUNT_W-1:0] visible;
   } queue_status_type;

   entry_type          slots [DEPTH];
   int unsigned        held;
   logic [COUNT_W-1:0] visible_cap;
   queue_status_type   awaited_status [$];
   int                 errors = 0;

   // Applies one request word to the shadow queue and returns the status word
   // that the block must answer with.
   function automatic queue_status_type apply_request(
      logic               kind,
      logic [TIME_W-1:0]  now,
      logic [LIFE_W-1:0]  life,
      logic [LEVEL_W-1:0] level,
      logic [TAG_W-1:0]   tag
   );
      queue_status_type   status;
      int unsigned        kept;
      logic [TIME_W-1:0]  age;
      logic [COUNT_W-1:0] cap;
      status = '0;
      if (kind == KIND_PUSH) begin
         if (held >= DEPTH) begin
            for (int i = 1; i < DEPTH; i++)
               slots[i-1] = slots[i];
            held = DEPTH - 1;
            status.dropped = 1'b1;
         end
         slots[held].tag      = tag;
         slots[held].level    = level;
         slots[held].arrival  = now;
         slots[held].lifetime = (life == '0) ? DEFAULT_LIFETIME : life;
         held++;
      end else begin
         kept = 0;
         for (int i = 0; i < held; i++) begin
            age = now - slots[i].arrival;
            if (age >= slots[i].lifetime) begin
               status.expired++;
            end else begin
               slots[kept] = slots[i];
               kept++;
            end
         end
         held = kept;
      end
      status.occupancy = COUNT_W'(held);
      cap = (visible_cap == '0) ? DEFAULT_VISIBLE : visible_cap;
      status.visible = (held < cap) ? COUNT_W'(held) : cap;
      return status;
   endfunction

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      queue_status_type want;
      if (reset) begin
         held        = 0;
         visible_cap = RESET_VISIBLE;
         awaited_status.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_status.size() == 0) begin
               $error("result word with no request waiting: expired %0d, occupancy %0d",
                      rsp_expired_count, rsp_occupancy);
               errors++;
            end else begin
               want = awaited_status.pop_front();
               compare_field("expired_count", want.expired, rsp_expired_count);
               compare_field("dropped_oldest", want.dropped, rsp_dropped_oldest);
               compare_field("occupancy", want.occupancy, rsp_occupancy);
               compare_field("visible_count", want.visible, rsp_visible_count);
            end
         end
         if (csr_wr_en)
            visible_cap = csr_wr_data;
         if (start && !busy)
            awaited_status.push_back(apply_request(req_kind, req_now_time, req_lifetime,
                                                   req_severity, req_payload_tag));
      end
      pending    <= awaited_status.size();
      fail_count <= errors;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the TTL expiry queue testbench: clock, reset, request stimulus and verdict.
// Depends on teq_pkg, ttl_expiry_queue_top and ttl_expiry_queue_checker.
module tb;
   import teq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // The settle wait outlasts the busy stretch of a tick over a full queue.
   localparam int SETTLE_CYCLES = DEPTH + 4;
   // Longest legal quiet stretch is a sender gap or a settle wait, both far
   // shorter than this limit, so this only fires when the block hangs.
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 205;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_kind = KIND_PUSH;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic [LIFE_W-1:0]    req_lifetime = '0;
   logic [LEVEL_W-1:0]   req_severity = '0;
   logic [TAG_W-1:0]     req_payload_tag = '0;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;
   logic                 rsp_strobe;
   logic [COUNT_W-1:0]   rsp_expired_count;
   logic                 rsp_dropped_oldest;
   logic [COUNT_W-1:0]   rsp_occupancy;
   logic [COUNT_W-1:0]   rsp_visible_count;

   int                   fail_count;
   int                   pending;
   int                   quiet_cycles = 0;
   // Millisecond clock that well-formed pushes and ticks follow.
   logic [TIME_W-1:0]    wall_ms;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ttl_expiry_queue_top #(.DEPTH(DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_now_time       (req_now_time),
      .req_lifetime       (req_lifetime),
      .req_severity       (req_severity),
      .req_payload_tag    (req_payload_tag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_expired_count  (rsp_expired_count),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_visible_count  (rsp_visible_count)
   );

   ttl_expiry_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_now_time       (req_now_time),
      .req_lifetime       (req_lifetime),
      .req_severity       (req_severity),
      .req_payload_tag    (req_payload_tag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_expired_count  (rsp_expired_count),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_visible_count  (rsp_visible_count),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   // The watchdog counts cycles in which neither a request word nor a result
   // word moves. Reaching the limit means the block has stopped answering.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Presents one request word and holds it until the block takes it. The word
   // is taken at the first edge where busy, sampled before the edge, is low.
   // Start is left high so that a following word can go out back to back.
   task automatic send_word(
      input logic               kind,
      input logic [TIME_W-1:0]  now,
      input logic [LIFE_W-1:0]  life,
      input logic [LEVEL_W-1:0] level,
      input logic [TAG_W-1:0]   tag
   );
      req_kind        <= kind;
      req_now_time    <= now;
      req_lifetime    <= life;
      req_severity    <= level;
      req_payload_tag <= tag;
      start           <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending, waits until every predicted result word has arrived and
   // then lets the block settle. The first edge makes sure the checker has
   // already counted the last word that was taken.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The visible limit is only written while the block is idle.
   task automatic write_visible_cap(input logic [COUNT_W-1:0] cap);
      csr_wr_data <= cap;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random word. Most words follow the millisecond clock so that entries
   // live for a few ticks and then expire; a few are pure noise with every
   // field drawn over its whole range, which also exercises wrapped ages.
   task automatic send_random_word(input int push_pct);
      int                roll;
      int                life_roll;
      logic [LIFE_W-1:0] life;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         send_word(1'($urandom_range(0, 1)), $urandom,
                   LIFE_W'($urandom_range(0, 24'hFF_FFFF)),
                   LEVEL_W'($urandom_range(0, 3)), TAG_W'($urandom_range(0, 16'hFFFF)));
      end else if (roll < 6 + (push_pct * 94) / 100) begin
         life_roll = $urandom_range(0, 19);
         if (life_roll == 0) begin
            life = '0;
         end else if (life_roll == 1) begin
            life = LIFE_W'($urandom_range(0, 24'hFF_FFFF));
         end else begin
            life = LIFE_W'($urandom_range(1, 400));
         end
         send_word(KIND_PUSH, wall_ms, life, LEVEL_W'($urandom_range(0, 3)),
                   TAG_W'($urandom_range(0, 16'hFFFF)));
      end else begin
         wall_ms = wall_ms + $urandom_range(0, 80);
         send_word(KIND_TICK, wall_ms, LIFE_W'($urandom_range(0, 24'hFF_FFFF)),
                   LEVEL_W'($urandom_range(0, 3)), TAG_W'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] cap_setting [PHASES];
      int                 sent;
      int                 burst;
      int                 push_pct;

      // Zero stands for the default of three, one is the smallest real cap,
      // sixteen matches the depth and thirty-one lies beyond any occupancy.
      cap_setting[0] = '0;
      cap_setting[1] = COUNT_W'(1);
      cap_setting[2] = COUNT_W'(16);
      cap_setting[3] = COUNT_W'(31);
      cap_setting[4] = COUNT_W'($urandom_range(1, 16));
      cap_setting[5] = COUNT_W'($urandom_range(0, 31));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words, run with the visible limit still at its reset value.
      // A tick on an empty queue expires nothing.
      send_word(KIND_TICK, 32'd0, '0, '0, '0);
      // A zero lifetime is stored as the default of 4000 ms.
      send_word(KIND_PUSH, 32'd1000, '0, 2'd0, 16'h0000);
      // Largest lifetime, arrival at the top of the time range.
      send_word(KIND_PUSH, 32'hFFFF_FFFF, 24'hFF_FFFF, 2'd3, 16'hFFFF);
      // One millisecond short of the default lifetime; the second entry's age
      // has wrapped through zero and stays small.
      send_word(KIND_TICK, 32'd4999, 24'hFF_FFFF, 2'd3, 16'hFFFF);
      // Age equal to the lifetime expires the entry.
      send_word(KIND_TICK, 32'd5000, '0, '0, '0);
      // A tick that is earlier than an arrival sees a huge wrapped age.
      send_word(KIND_PUSH, 32'd50, 24'd1, 2'd2, 16'h5A5A);
      send_word(KIND_TICK, 32'd10, '0, '0, '0);
      // Fill the queue with a mix of short and longer lifetimes.
      for (int i = 0; i < DEPTH - 1; i++)
         send_word(KIND_PUSH, 32'd200, (i % 2) ? 24'd1 : 24'd300, 2'(i),
                   TAG_W'(16'h1000 + i));
      // One push beyond full drops the oldest entry.
      send_word(KIND_PUSH, 32'd200, 24'd1, 2'd1, 16'hA5A5);
      // Half of the queue expires and the rest must close ranks in order.
      send_word(KIND_TICK, 32'd201, '0, '0, '0);

      // Random phases, each with its own cap. Between phases the sender waits
      // for every outstanding result before the register is touched.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_visible_cap(cap_setting[phase]);
         // One phase starts just below the wrap of the millisecond clock.
         wall_ms = (phase == 2) ? 32'hFFFF_F000 + $urandom_range(0, 2048) : $urandom;
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            burst    = $urandom_range(1, 24);
            push_pct = $urandom_range(35, 90);
            for (int k = 0; k < burst; k++)
               send_random_word(push_pct);
            sent += burst;
            // Some bursts run straight into the next one; the others leave a
            // gap that can land on any cycle of a tick in progress.
            if ($urandom_range(0, 3) != 0)
               idle_for($urandom_range(1, 25));
            if ($urandom_range(0, 39) == 0)
               drain_results();
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/teq_pkg.sv
rtl/core/teq_ctrl.sv
rtl/core/teq_datapath.sv
rtl/core/ttl_expiry_queue_top.sv
bench/ttl_expiry_queue_checker.sv
bench/tb.sv
